>>> rtl/wmsd_pkg.sv
// Package for the middle-square Weyl dice unit.
// Holds widths, constants and the sequencer state type.
// No dependencies; every other file of the block uses it.
package wmsd_pkg;

    localparam int unsigned WORD_W  = 31;
    localparam int unsigned STATE_W = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned TRIES_W = 24;
    localparam int unsigned STEP_W  = 5;

    localparam logic [STATE_W-1:0] WEYL_INC = 64'hB5AD_4ECE_DA1C_E2A9;
    localparam logic [WORD_W-1:0]  RAW_MAX  = 31'h7FFF_FFFF;
    localparam logic [STEP_W-1:0]  DIV_LAST = 5'(WORD_W - 1);

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_SQ_LO = 6'b000100,
        ST_SQ_HI = 6'b001000,
        ST_MIX   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

>>> rtl/wmsd_if.sv
// Valid/ready channel interfaces of the middle-square Weyl dice unit.
// Depends on wmsd_pkg for the field widths.
interface wmsd_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [wmsd_pkg::WORD_W-1:0]  seed_value;
    logic [wmsd_pkg::WORD_W-1:0]  dice_sides;

    modport source (output valid, output cmd, output seed_value, output dice_sides,
                     input ready);
    modport sink   (input valid, input cmd, input seed_value, input dice_sides,
                    output ready);
endinterface

interface wmsd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [wmsd_pkg::WORD_W-1:0]  dice_value;

    modport source (output valid, output dice_value, input ready);
    modport sink   (input valid, input dice_value, output ready);
endinterface

>>> rtl/weyl_middle_square_dice_unit.sv
// Middle-square Weyl dice unit: a reseed gives no result.
// A draw forms floor(0x7fffffff/d) in the shared divider, runs generator tries (2 multiplier
// passes, 1 mix, 31 divide steps each) and then loads the result register; a new request is
// taken only once that register is loaded. With d = 0 the draw skips the divider and loads a
// zero result. A finished draw waits while an earlier result is not taken; a reseed is not
// blocked by a waiting result.
// rst_n clears the square state, the Weyl counter and all control asynchronously.
module weyl_middle_square_dice_unit (
    input  logic           clk,
    input  logic           rst_n,
    wmsd_req_if.sink       req,
    wmsd_rsp_if.source     rsp
);

    wmsd_pkg::state_t state_reg, state_next;

    logic [wmsd_pkg::STATE_W-1:0] sq_reg, sq_next;
    logic [wmsd_pkg::STATE_W-1:0] weyl_reg, weyl_next;
    logic [wmsd_pkg::STATE_W-1:0] prod_reg, prod_next;
    logic [wmsd_pkg::STATE_W-1:0] acc_reg, acc_next;
    logic [wmsd_pkg::WORD_W-1:0]  d_reg, d_next;
    logic [wmsd_pkg::WORD_W-1:0]  dvsr_reg, dvsr_next;
    logic [wmsd_pkg::WORD_W-1:0]  quo_reg, quo_next;
    logic [wmsd_pkg::WORD_W-1:0]  rem_reg, rem_next;
    logic [wmsd_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [wmsd_pkg::TRIES_W-1:0] tries_reg, tries_next;
    logic                         phase_reg, phase_next;
    logic [wmsd_pkg::WORD_W-1:0]  res_reg, res_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    logic [wmsd_pkg::WORD_W-1:0]  out_reg, out_next;

    // Shared 32x32 multiplier.
    logic [wmsd_pkg::HALF_W-1:0]  mul_a;
    logic [wmsd_pkg::HALF_W-1:0]  mul_b;
    logic [wmsd_pkg::STATE_W-1:0] mul_p;

    // One restoring divide step.
    logic [wmsd_pkg::WORD_W:0]    div_shift;
    logic                         div_ge;
    logic [wmsd_pkg::WORD_W:0]    div_diff;
    logic [wmsd_pkg::WORD_W-1:0]  step_quo;
    logic [wmsd_pkg::WORD_W-1:0]  step_rem;

    logic [wmsd_pkg::STATE_W-1:0] mix_sum;
    logic                         req_fire;

    assign mul_a = (state_reg == wmsd_pkg::ST_SQ_HI) ? sq_reg[63:32] : sq_reg[31:0];
    assign mul_b = sq_reg[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign div_shift = {rem_reg, quo_reg[wmsd_pkg::WORD_W-1]};
    assign div_ge    = div_shift >= {1'b0, dvsr_reg};
    assign div_diff  = div_shift - {1'b0, dvsr_reg};
    assign step_rem  = div_ge ? div_diff[wmsd_pkg::WORD_W-1:0]
                              : div_shift[wmsd_pkg::WORD_W-1:0];
    assign step_quo  = {quo_reg[wmsd_pkg::WORD_W-2:0], div_ge};

    // Cross term hi*lo enters twice, hence the shift by 33.
    assign mix_sum = acc_reg + {prod_reg[30:0], 33'b0};

    assign req.ready  = (state_reg == wmsd_pkg::ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.dice_value = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        sq_next        = sq_reg;
        weyl_next      = weyl_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        dvsr_next      = dvsr_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        tries_next     = tries_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        out_next       = out_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            wmsd_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.cmd == wmsd_pkg::CMD_SEED)
                    begin
                        sq_next   = {33'b0, req.seed_value};
                        weyl_next = '0;
                    end
                    else if (req.dice_sides == '0)
                    begin
                        res_next   = '0;
                        state_next = wmsd_pkg::ST_OUT;
                    end
                    else
                    begin
                        d_next     = req.dice_sides;
                        dvsr_next  = req.dice_sides;
                        quo_next   = wmsd_pkg::RAW_MAX;
                        rem_next   = '0;
                        step_next  = '0;
                        tries_next = '0;
                        phase_next = 1'b0;
                        state_next = wmsd_pkg::ST_DIV;
                    end
                end
            end
            wmsd_pkg::ST_DIV:
            begin
                quo_next  = step_quo;
                rem_next  = step_rem;
                step_next = step_reg + 5'd1;
                if (step_reg == wmsd_pkg::DIV_LAST)
                begin
                    if (!phase_reg)
                    begin
                        // The quotient becomes the divisor for every raw word.
                        dvsr_next  = step_quo;
                        phase_next = 1'b1;
                        state_next = wmsd_pkg::ST_SQ_LO;
                    end
                    else if (step_quo < d_reg)
                    begin
                        res_next   = step_quo;
                        state_next = wmsd_pkg::ST_OUT;
                    end
                    else if (tries_reg == '1)
                    begin
                        res_next   = d_reg - 31'd1;
                        state_next = wmsd_pkg::ST_OUT;
                    end
                    else
                    begin
                        tries_next = tries_reg + 24'd1;
                        state_next = wmsd_pkg::ST_SQ_LO;
                    end
                end
            end
            wmsd_pkg::ST_SQ_LO:
            begin
                prod_next  = mul_p;
                weyl_next  = weyl_reg + wmsd_pkg::WEYL_INC;
                state_next = wmsd_pkg::ST_SQ_HI;
            end
            wmsd_pkg::ST_SQ_HI:
            begin
                prod_next  = mul_p;
                acc_next   = prod_reg + weyl_reg;
                state_next = wmsd_pkg::ST_MIX;
            end
            wmsd_pkg::ST_MIX:
            begin
                sq_next    = {mix_sum[31:0], mix_sum[63:32]};
                quo_next   = mix_sum[62:32];
                rem_next   = '0;
                step_next  = '0;
                state_next = wmsd_pkg::ST_DIV;
            end
            wmsd_pkg::ST_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = wmsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wmsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wmsd_pkg::ST_IDLE;
            sq_reg        <= '0;
            weyl_reg      <= '0;
            step_reg      <= '0;
            tries_reg     <= '0;
            phase_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sq_reg        <= sq_next;
            weyl_reg      <= weyl_next;
            step_reg      <= step_next;
            tries_reg     <= tries_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        d_reg    <= d_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

>>> rtl/wmsd_checker.sv
// Port-level checks for the middle-square Weyl dice unit, bound to its top level.
// Depends on wmsd_pkg and on the top level's channel ports.
module wmsd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        req_cmd,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [wmsd_pkg::WORD_W-1:0] rsp_dice_value
);

    // A pending result stays offered until its transaction completes.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before its transaction completed");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_dice_value))
        else $error("stalled result changed");

    // A draw occupies the unit, a reseed does not.
    a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == wmsd_pkg::CMD_DRAW) |=> !req_ready)
        else $error("unit still ready after taking a draw");

    a_seed_free: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == wmsd_pkg::CMD_SEED) |=> req_ready)
        else $error("unit went busy after a reseed");

    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready)
        else $error("new result shown while the unit is still busy");

endmodule

bind weyl_middle_square_dice_unit wmsd_checker u_wmsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_cmd        (req.cmd),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_dice_value (rsp.dice_value)
);

>>> bench/tb_weyl_middle_square_dice_unit.sv
`timescale 1ns / 100ps
// Testbench for weyl_middle_square_dice_unit: directed and random reseed and draw traffic.
// A local generator model predicts every draw; results are checked in order as they arrive.
// Depends on wmsd_pkg, the channel interfaces of wmsd_if.sv and the block's RTL.
module tb_weyl_middle_square_dice_unit;

    typedef logic [wmsd_pkg::WORD_W-1:0]  word_t;
    typedef logic [wmsd_pkg::STATE_W-1:0] gen_t;

    localparam int unsigned IDLE_LIMIT   = 20000;
    localparam int unsigned RANDOM_ITEMS = 650;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES  = 400;

    logic clk;
    logic rst_n;

    wmsd_req_if req_ch();
    wmsd_rsp_if rsp_ch();

    weyl_middle_square_dice_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Generator state as the block should hold it after every accepted request.
    gen_t  square_model;
    gen_t  weyl_model;
    word_t dice_due[$];

    int          error_count;
    int          burst_left;
    int          hold_left;
    bit          sender_gaps;
    bit          receiver_stalls;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic word_t roll_die(input word_t sides);
        gen_t        divisor;
        gen_t        mixed;
        gen_t        quotient;
        int unsigned tries;
        if (sides == '0)
            return '0;
        divisor = gen_t'(wmsd_pkg::RAW_MAX) / gen_t'(sides);
        for (tries = 0; tries < (1 << wmsd_pkg::TRIES_W); tries++)
        begin
            weyl_model   = weyl_model + wmsd_pkg::WEYL_INC;
            mixed        = square_model * square_model + weyl_model;
            square_model = {mixed[wmsd_pkg::HALF_W-1:0],
                            mixed[wmsd_pkg::STATE_W-1:wmsd_pkg::HALF_W]};
            quotient     = gen_t'(square_model[wmsd_pkg::WORD_W-1:0]) / divisor;
            if (quotient < gen_t'(sides))
                return quotient[wmsd_pkg::WORD_W-1:0];
        end
        return sides - 1'b1;
    endfunction

    function automatic word_t pick_sides();
        int unsigned sh;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return word_t'($urandom_range(1, 12));
            4:          return word_t'($urandom_range(13, 100000));
            5:
            begin
                sh = $urandom_range(0, wmsd_pkg::WORD_W - 1);
                return (word_t'(1) << sh) + word_t'($urandom_range(0, 2)) - word_t'(1);
            end
            6, 7:       return word_t'($urandom);
            8:          return word_t'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
            default:    return ($urandom_range(0, 3) == 0) ? '0
                                : wmsd_pkg::RAW_MAX - word_t'($urandom_range(0, 3));
        endcase
    endfunction

    // Offers one request and returns once it has been accepted. Unless a gap is inserted, valid
    // stays high so that back-to-back requests leave no idle gap.
    task automatic send_request(input logic cmd, input word_t seed, input word_t sides);
        int unsigned gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(0, 24);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.seed_value <= seed;
        req_ch.dice_sides <= sides;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (cmd == wmsd_pkg::CMD_SEED)
        begin
            square_model = gen_t'(seed);
            weyl_model   = '0;
        end
        else
            dice_due.push_back(roll_die(sides));
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_random_request();
        word_t seed;
        if ($urandom_range(0, 99) < 10)
        begin
            seed = ($urandom_range(0, 3) == 0) ? word_t'($urandom_range(0, 15))
                                               : word_t'($urandom);
            send_request(wmsd_pkg::CMD_SEED, seed, word_t'($urandom));
        end
        else
            send_request(wmsd_pkg::CMD_DRAW, word_t'($urandom), pick_sides());
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (dice_due.size() != 0);
    endtask

    task automatic test_draw_from_reset();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        send_request(wmsd_pkg::CMD_DRAW, wmsd_pkg::RAW_MAX, word_t'(6));
        send_request(wmsd_pkg::CMD_DRAW, '0, word_t'(1));
        send_request(wmsd_pkg::CMD_DRAW, wmsd_pkg::RAW_MAX, wmsd_pkg::RAW_MAX);
        wait_drained();
    endtask

    task automatic test_directed_cases();
        send_request(wmsd_pkg::CMD_SEED, '0, wmsd_pkg::RAW_MAX);
        send_request(wmsd_pkg::CMD_DRAW, wmsd_pkg::RAW_MAX, word_t'(1));
        send_request(wmsd_pkg::CMD_DRAW, '0, word_t'(2));
        send_request(wmsd_pkg::CMD_SEED, wmsd_pkg::RAW_MAX, '0);
        // A draw with zero sides must leave the generator untouched for the next draw.
        send_request(wmsd_pkg::CMD_DRAW, wmsd_pkg::RAW_MAX, '0);
        send_request(wmsd_pkg::CMD_DRAW, '0, word_t'(6));
        send_request(wmsd_pkg::CMD_DRAW, '0, wmsd_pkg::RAW_MAX);
        send_request(wmsd_pkg::CMD_DRAW, '0, word_t'(32'h4000_0000));
        send_request(wmsd_pkg::CMD_DRAW, '0, word_t'(32'h4000_0001));
        send_request(wmsd_pkg::CMD_DRAW, '0, word_t'(32'h3FFF_FFFF));
        send_request(wmsd_pkg::CMD_SEED, word_t'(32'h2AAA_AAAA), word_t'(32'h5555_5555));
        send_request(wmsd_pkg::CMD_SEED, word_t'(32'h5555_5555), word_t'(32'h2AAA_AAAA));
        send_request(wmsd_pkg::CMD_DRAW, word_t'(32'h2AAA_AAAA), word_t'(32'h5555_5555));
        send_request(wmsd_pkg::CMD_DRAW, word_t'(32'h5555_5555), word_t'(32'h2AAA_AAAA));
        send_request(wmsd_pkg::CMD_DRAW, wmsd_pkg::RAW_MAX, '0);
        send_request(wmsd_pkg::CMD_DRAW, wmsd_pkg::RAW_MAX, word_t'(3));
        wait_drained();
    endtask

    // The receiver holds off while requests keep coming, so a finished draw sits in the
    // output register; a reseed is still taken in that state.
    task automatic test_receiver_holdoff();
        sender_gaps = 1'b0;
        hold_left   = HOLD_CYCLES;
        send_request(wmsd_pkg::CMD_DRAW, '0, word_t'(10));
        send_request(wmsd_pkg::CMD_SEED, word_t'(123), '0);
        send_request(wmsd_pkg::CMD_DRAW, '0, word_t'(10));
        repeat (20) send_random_request();
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Each window of 160 transactions opens with a stretch free of idling.
            sender_gaps     = (i % 160) >= 30;
            receiver_stalls = (i % 160) >= 30;
            send_random_request();
            if (i % 200 == 199)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin : rsp_ready_drive
        int          phase;
        logic [15:0] mask;
        rsp_ch.ready = 1'b0;
        phase        = 0;
        mask         = '1;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!receiver_stalls)
                rsp_ch.ready <= 1'b1;
            else
            begin
                rsp_ch.ready <= mask[phase];
                phase = (phase + 1) % 16;
                if (phase == 0)
                    mask = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
            end
        end
    end

    initial
    begin : dice_check
        word_t want;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (dice_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t: dice_value expected none, actual %0d", $time,
                             rsp_ch.dice_value);
                end
                else
                begin
                    want = dice_due.pop_front();
                    if (rsp_ch.dice_value !== want)
                    begin
                        error_count++;
                        $display("%0t: dice_value expected %0d, actual %0d", $time,
                                 want, rsp_ch.dice_value);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        error_count       = 0;
        burst_left        = 0;
        hold_left         = 0;
        sender_gaps       = 1'b0;
        receiver_stalls   = 1'b0;
        square_model      = '0;
        weyl_model        = '0;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = wmsd_pkg::CMD_SEED;
        req_ch.seed_value = '0;
        req_ch.dice_sides = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_draw_from_reset();
        test_directed_cases();
        test_receiver_holdoff();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/wmsd_pkg.sv
rtl/wmsd_if.sv
rtl/weyl_middle_square_dice_unit.sv
rtl/wmsd_checker.sv
bench/tb_weyl_middle_square_dice_unit.sv
